@@ rtl/core/frame_arrival_predictor_core_defines.svh @@
// Assertion macros shared by the frame arrival predictor RTL.
`ifndef FRAME_ARRIVAL_PREDICTOR_CORE_DEFINES_SVH
`define FRAME_ARRIVAL_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fap_pkg.sv @@
// Package: constants, codes and shared types of the frame arrival predictor.
`default_nettype none
package fap_pkg;
    localparam int RING_DEPTH_DEF = 30;
    localparam int TIME_BITS_DEF  = 48;
    localparam int IVL_W          = 20;
    localparam int THR_W          = 21;
    localparam int RATE_W         = 8;
    localparam int CFG_IDX_W      = 8;

    localparam logic [25:0] IDLE_LONG    = 26'd60000000;
    localparam logic [16:0] IDLE_SHORT   = 17'd100000;
    localparam logic [16:0] INTERVAL_CAP = 17'd100000;
    localparam logic [19:0] PERIOD_NUM   = 20'd1000000;
    localparam logic [20:0] THRESH_NUM   = 21'd2000000;
    localparam logic [19:0] INTERVAL_MAX = 20'd1000000;

    // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x below 1024
    localparam logic [7:0] DIV5_MUL   = 8'd205;
    localparam int         DIV5_SHIFT = 10;

    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_PREDICT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_MODE   = 8'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage
`default_nettype wire

@@ rtl/core/frame_arrival_predictor_core.sv @@
// Top level: frame arrival predictor with ring store, gap selection and shared divider.
`default_nettype none
`include "frame_arrival_predictor_core_defines.svh"
// Keeps the last RING_DEPTH arrival timestamps and answers each input word with one
// result word. A record word goes from S_IDLE to S_DONE. A predict word runs its
// divisions (none, two or three) on one shared restoring divider. With two or more
// samples outside idle mode it also runs a gap pass and a 40th-percentile selection.
// The selection compares each candidate gap against all n gaps from the gap memory,
// n = count-1. The input is not ready while a word is at work;
// one finished result may wait in the output register while the next word is taken.
// Configuration writes are always taken and must be made while the block is idle.
module frame_arrival_predictor_core #(
    parameter int RING_DEPTH = fap_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = fap_pkg::TIME_BITS_DEF,
    parameter int S_DATA_W   = ((2 * TIME_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((TIME_BITS + fap_pkg::IVL_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // now_time, last_poll_time
    input  wire logic [S_DATA_W-1:0]           s_tdata,
    // command
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // predicted_time, interval_used
    output logic      [M_DATA_W-1:0]           m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fap_pkg::RATE_W-1:0]    cfg_data
);
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int IVL_W = fap_pkg::IVL_W;
    localparam int THR_W = fap_pkg::THR_W;
    localparam int TW3   = TIME_BITS + 2;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_REF   = 15'h0002,
        S_CHK   = 15'h0004,
        S_PER   = 15'h0008,
        S_THR   = 15'h0010,
        S_GAP   = 15'h0020,
        S_CAND  = 15'h0040,
        S_SCAN  = 15'h0080,
        S_JUDGE = 15'h0100,
        S_ADJ   = 15'h0200,
        S_AGE   = 15'h0400,
        S_NEXT  = 15'h0800,
        S_FIN   = 15'h1000,
        S_DONE  = 15'h2000,
        S_GLAST = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [fap_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic                       idle_reg, idle_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]              gidx_reg, gidx_next;
    logic [AW-1:0]              ci_reg, ci_next;
    logic [AW-1:0]              j_reg, j_next;
    logic [CW-1:0]              lt_reg, lt_next;
    logic [CW-1:0]              le_reg, le_next;
    logic [AW-1:0]              gap_raddr_reg, gap_raddr_next;

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] poll_reg, poll_next;
    logic [TIME_BITS-1:0] ref_reg, ref_next;
    logic [TIME_BITS-1:0] age_reg, age_next;
    logic [TIME_BITS-1:0] prev_reg, prev_next;
    logic [TIME_BITS-1:0] cand_reg, cand_next;
    logic [TIME_BITS-1:0] nxt_reg, nxt_time_next;
    logic [IVL_W-1:0]     period_reg, period_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [IVL_W-1:0]     ivl_reg, ivl_next;
    logic [TIME_BITS-1:0] res_pred_reg, res_pred_next;
    logic [IVL_W-1:0]     res_ivl_reg, res_ivl_next;

    logic                 m_valid_reg, m_valid_next;
    logic [TIME_BITS-1:0] m_pred_reg, m_pred_next;
    logic [IVL_W-1:0]     m_ivl_reg, m_ivl_next;

    logic                 ring_we;
    logic [TIME_BITS-1:0] ring_rdata;
    logic                 gap_we;
    logic [AW-1:0]        gap_waddr;
    logic [TIME_BITS-1:0] gap_wdata;
    logic [TIME_BITS-1:0] gap_rdata;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_num;
    logic [IVL_W-1:0]     div_den;
    fap_pkg::div_stat_t   div_stat;
    logic [TIME_BITS-1:0] div_quot;
    logic [IVL_W-1:0]     div_rem;

    logic                 s_acc;
    logic [AW-1:0]        newest;
    logic [CW-1:0]        n_gaps;
    logic [CW-1:0]        sel_rank;
    logic [CW+8:0]        rank_prod;
    logic [IVL_W-1:0]     rate_div;
    logic [TIME_BITS-1:0] v_half;
    logic [TIME_BITS-1:0] v_cap;
    logic [TIME_BITS-1:0] kint;
    logic [TIME_BITS-1:0] prev_t;
    logic [TIME_BITS-1:0] lag;
    logic [TW3-1:0]       dist3;
    logic                 near;

    fap_ram #(.DEPTH(RING_DEPTH), .DW(TIME_BITS), .AW(AW)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (s_tdata[TIME_BITS-1:0]),
        .raddr (rd_ptr_next),
        .rdata (ring_rdata)
    );

    fap_ram #(.DEPTH(RING_DEPTH), .DW(TIME_BITS), .AW(AW)) u_gaps (
        .aclk  (aclk),
        .we    (gap_we),
        .waddr (gap_waddr),
        .wdata (gap_wdata),
        .raddr (gap_raddr_next),
        .rdata (gap_rdata)
    );

    fap_div #(.NUM_W(TIME_BITS), .DEN_W(IVL_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // fixed helpers
    always_comb begin
        s_acc     = s_tvalid && s_tready;
        newest    = (tail_reg == '0) ? AW'(RING_DEPTH - 1) : tail_reg - 1'b1;
        n_gaps    = count_reg - 1'b1;
        rank_prod = ({n_gaps, 1'b0} + (CW+9)'(0)) * (CW+9)'(fap_pkg::DIV5_MUL);
        sel_rank  = CW'(rank_prod >> fap_pkg::DIV5_SHIFT);
        rate_div  = (rate_reg == '0) ? IVL_W'(1) : IVL_W'(rate_reg);
        v_half    = ({{(TIME_BITS-THR_W){1'b0}}, thr_reg} <= cand_reg) ? (cand_reg >> 1)
                                                                        : cand_reg;
        v_cap     = (v_half > TIME_BITS'(fap_pkg::INTERVAL_CAP))
                    ? TIME_BITS'(fap_pkg::INTERVAL_CAP) : v_half;
        kint      = age_reg - TIME_BITS'(div_rem)
                    + ((div_rem != '0) ? TIME_BITS'(ivl_reg) : '0);
        prev_t    = nxt_reg - TIME_BITS'(ivl_reg);
        lag       = now_reg - prev_reg;
        dist3     = (TW3'(lag) + TW3'(1)) + ((TW3'(lag) + TW3'(1)) << 1);
        near      = (dist3 <= TW3'(ivl_reg)) && (prev_reg > ref_reg);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        idle_next      = idle_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        gidx_next      = gidx_reg;
        ci_next        = ci_reg;
        j_next         = j_reg;
        lt_next        = lt_reg;
        le_next        = le_reg;
        gap_raddr_next = gap_raddr_reg;
        now_next       = now_reg;
        poll_next      = poll_reg;
        ref_next       = ref_reg;
        age_next       = age_reg;
        prev_next      = prev_reg;
        cand_next      = cand_reg;
        nxt_time_next  = nxt_reg;
        period_next    = period_reg;
        thr_next       = thr_reg;
        ivl_next       = ivl_reg;
        res_pred_next  = res_pred_reg;
        res_ivl_next   = res_ivl_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_pred_next    = m_pred_reg;
        m_ivl_next     = m_ivl_reg;
        ring_we        = 1'b0;
        gap_we         = 1'b0;
        gap_waddr      = gidx_reg - 1'b1;
        gap_wdata      = prev_reg - ring_rdata;
        div_start      = 1'b0;
        div_num        = TIME_BITS'(fap_pkg::PERIOD_NUM);
        div_den        = rate_div;

        // take register writes
        if (cfg_valid) begin
            if (cfg_index == fap_pkg::REG_TARGET_RATE) begin
                rate_next = cfg_data;
            end else if (cfg_index == fap_pkg::REG_IDLE_MODE) begin
                idle_next = cfg_data[0];
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    now_next  = s_tdata[TIME_BITS-1:0];
                    poll_next = s_tdata[2*TIME_BITS-1:TIME_BITS];
                    if (s_tuser == fap_pkg::CMD_RECORD) begin
                        ring_we       = 1'b1;
                        tail_next     = (tail_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                          : tail_reg + 1'b1;
                        if (count_reg != CW'(RING_DEPTH)) begin
                            count_next = count_reg + 1'b1;
                        end
                        res_pred_next = '0;
                        res_ivl_next  = '0;
                        state_next    = S_DONE;
                    end else begin
                        rd_ptr_next = newest;
                        state_next  = S_REF;
                    end
                end
            end
            S_REF: begin
                ref_next   = (count_reg != '0) ? ring_rdata : now_reg;
                age_next   = now_reg - ((count_reg != '0) ? ring_rdata : now_reg);
                state_next = S_CHK;
            end
            S_CHK: begin
                res_pred_next = poll_reg + TIME_BITS'(fap_pkg::IDLE_SHORT);
                res_ivl_next  = '0;
                if (idle_reg && age_reg > TIME_BITS'(fap_pkg::IDLE_LONG)) begin
                    count_next = CW'(1);
                    state_next = S_DONE;
                end else if (idle_reg && age_reg > TIME_BITS'(fap_pkg::IDLE_SHORT)) begin
                    state_next = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_PER;
                end
            end
            S_PER: begin
                if (div_stat.done) begin
                    period_next = div_quot[IVL_W-1:0];
                    div_start   = 1'b1;
                    if (idle_reg || count_reg < CW'(2)) begin
                        ivl_next   = div_quot[IVL_W-1:0];
                        div_num    = age_reg;
                        div_den    = div_quot[IVL_W-1:0];
                        state_next = S_AGE;
                    end else begin
                        div_num    = TIME_BITS'(fap_pkg::THRESH_NUM);
                        state_next = S_THR;
                    end
                end
            end
            S_THR: begin
                if (div_stat.done) begin
                    thr_next   = div_quot[THR_W-1:0];
                    gidx_next  = '0;
                    state_next = S_GAP;
                end
            end
            S_GAP: begin
                // ring data is sample gidx, newest first
                prev_next = ring_rdata;
                gap_we    = (gidx_reg != '0);
                if (CW'(gidx_reg) == n_gaps) begin
                    ci_next        = '0;
                    gap_raddr_next = '0;
                    state_next     = S_GLAST;
                end else begin
                    gidx_next   = gidx_reg + 1'b1;
                    rd_ptr_next = (rd_ptr_reg == '0) ? AW'(RING_DEPTH - 1)
                                                     : rd_ptr_reg - 1'b1;
                end
            end
            S_GLAST: begin
                // let the last gap write land before the first candidate read
                state_next = S_CAND;
            end
            S_CAND: begin
                cand_next      = gap_rdata;
                j_next         = '0;
                lt_next        = '0;
                le_next        = '0;
                gap_raddr_next = '0;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                // rank the candidate against every gap
                lt_next = lt_reg + CW'(gap_rdata < cand_reg);
                le_next = le_reg + CW'(gap_rdata <= cand_reg);
                if (CW'(j_reg) == n_gaps - 1'b1) begin
                    state_next = S_JUDGE;
                end else begin
                    j_next         = j_reg + 1'b1;
                    gap_raddr_next = j_reg + 1'b1;
                end
            end
            S_JUDGE: begin
                if (lt_reg <= sel_rank && sel_rank < le_reg) begin
                    state_next = S_ADJ;
                end else begin
                    ci_next        = ci_reg + 1'b1;
                    gap_raddr_next = ci_reg + 1'b1;
                    state_next     = S_CAND;
                end
            end
            S_ADJ: begin
                ivl_next   = (v_cap < TIME_BITS'(period_reg)) ? period_reg
                                                              : v_cap[IVL_W-1:0];
                div_start  = 1'b1;
                div_num    = age_reg;
                div_den    = (v_cap < TIME_BITS'(period_reg)) ? period_reg
                                                              : v_cap[IVL_W-1:0];
                state_next = S_AGE;
            end
            S_AGE: begin
                if (div_stat.done) begin
                    nxt_time_next = ref_reg + kint;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT: begin
                // hold the previous multiple for the near check
                prev_next  = prev_t;
                state_next = S_FIN;
            end
            S_FIN: begin
                res_pred_next = near ? now_reg : nxt_reg;
                res_ivl_next  = ivl_reg;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pred_next  = res_pred_reg;
                    m_ivl_next   = res_ivl_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rate_reg    <= fap_pkg::RATE_W'(60);
            idle_reg    <= 1'b0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rate_reg    <= rate_next;
            idle_reg    <= idle_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg    <= rd_ptr_next;
        gidx_reg      <= gidx_next;
        ci_reg        <= ci_next;
        j_reg         <= j_next;
        lt_reg        <= lt_next;
        le_reg        <= le_next;
        gap_raddr_reg <= gap_raddr_next;
        now_reg       <= now_next;
        poll_reg      <= poll_next;
        ref_reg       <= ref_next;
        age_reg       <= age_next;
        prev_reg      <= prev_next;
        cand_reg      <= cand_next;
        nxt_reg       <= nxt_time_next;
        period_reg    <= period_next;
        thr_reg       <= thr_next;
        ivl_reg       <= ivl_next;
        res_pred_reg  <= res_pred_next;
        res_ivl_reg   <= res_ivl_next;
        m_pred_reg    <= m_pred_next;
        m_ivl_reg     <= m_ivl_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_DATA_W'({m_ivl_reg, m_pred_reg});

    `FAP_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(RING_DEPTH), "sample count above ring depth")
    `FAP_ASSERT_IMP(a_div_free, aclk, aresetn, div_start, !div_stat.busy, "divider started while busy")
    `FAP_ASSERT_IMP(a_ivl_range, aclk, aresetn, m_valid_reg, m_ivl_reg <= fap_pkg::INTERVAL_MAX, "interval out of range")
    `FAP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid_reg && !m_tready, m_valid_reg, "result dropped while stalled")
endmodule
`default_nettype wire

@@ rtl/core/fap_ram.sv @@
// Single-write, single-read memory with registered read data.
`default_nettype none
module fap_ram #(
    parameter int DEPTH = fap_pkg::RING_DEPTH_DEF,
    parameter int DW    = fap_pkg::TIME_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ rtl/core/fap_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fap_div #(
    parameter int NUM_W = fap_pkg::TIME_BITS_DEF,
    parameter int DEN_W = fap_pkg::IVL_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output fap_pkg::div_stat_t    stat,
    output logic      [NUM_W-1:0] quot,
    output logic      [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // one shift-subtract step
    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            num_next = num;
            rem_next = '0;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[NUM_W-2:0], qbit};
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // hold operands
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = num_reg;
    assign rem       = rem_reg;
endmodule
`default_nettype wire
